[rtl/core/xor_cipher_crc32_frame_check_core_defines.svh]
// Assertion macros for the XOR cipher and CRC-32 frame check core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef XOR_CIPHER_CRC32_FRAME_CHECK_CORE_DEFINES_SVH
`define XOR_CIPHER_CRC32_FRAME_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define XCC_ASSERT_SAME(label, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
        else $error("xcc core: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define XCC_ASSERT_NEXT(label, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
        else $error("xcc core: next-cycle check failed");

`endif

[rtl/core/xcc_pkg.sv]
// Package for the XOR cipher and CRC-32 frame check core.
// Holds CRC constants, field widths and register indexes; no dependencies.
`default_nettype none

package xcc_pkg;

    localparam int BYTE_W = 8;
    localparam int CRC_W  = 32;
    localparam int TDATA_W = 40;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_XOROUT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_TOPBIT = 32'h8000_0000;

    localparam logic [CFG_INDEX_W-1:0] REG_CIPHER_KEY = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_MODE = 1'd1;

endpackage

`default_nettype wire

[rtl/core/xcc_crc_byte.sv]
// One-byte CRC-32 update, MSB first, as an unrolled eight-step XOR network.
// Depends on xcc_pkg for the polynomial and widths.
`default_nettype none

module xcc_crc_byte (
    input  wire logic [xcc_pkg::CRC_W-1:0]  crc_in,
    input  wire logic [xcc_pkg::BYTE_W-1:0] byte_in,
    output logic      [xcc_pkg::CRC_W-1:0]  crc_out
);
    import xcc_pkg::*;

    always_comb
    begin
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {byte_in, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if ((crc & CRC_TOPBIT) != '0)
            begin
                crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[CRC_W-2:0], 1'b0};
            end
        end
        crc_out = crc;
    end

endmodule

`default_nettype wire

[rtl/core/xor_cipher_crc32_frame_check_core.sv]
// XOR cipher with CRC-32/BZIP2 frame check: top level.
// Depends on xcc_pkg, xcc_crc_byte and the assertion macro header.
// The core takes one word per clock cycle unless m_tready stalls the output,
// and passes each result through an input register and an output register. The
// rate is set by the running CRC register, which is updated once per word by
// a combinational eight-bit XOR network between the two registers. Each input
// word is one payload byte; in generate mode it is enciphered with the key and
// the ciphertext enters the CRC, in check mode the received byte enters the
// CRC and the deciphered byte is passed out. On the word marked by tlast the
// final CRC is reported, compared with the expected value in check mode, and
// the CRC register is reloaded for the next frame.
`default_nettype none
`include "xor_cipher_crc32_frame_check_core_defines.svh"

module xor_cipher_crc32_frame_check_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [xcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [xcc_pkg::BYTE_W-1:0]       cfg_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: data_byte[7:0], header_crc[39:8].
    input  wire logic [xcc_pkg::TDATA_W-1:0]      s_tdata,
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // Fields from bit 0: out_byte[7:0], crc_value[39:8].
    output logic      [xcc_pkg::TDATA_W-1:0]      m_tdata,
    output logic                                  m_tlast,
    // Fields from bit 0: crc_match[0].
    output logic                                  m_tuser
);
    import xcc_pkg::*;

    logic [BYTE_W-1:0] key_reg;
    logic              mode_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic [CRC_W-1:0]  crc_next;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic [CRC_W-1:0]  in_expect_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [CRC_W-1:0]  out_crc_reg;
    logic              out_last_reg;
    logic              out_match_reg;

    logic              out_adv;
    logic              in_adv;
    logic [BYTE_W-1:0] xored;
    logic [BYTE_W-1:0] cipher_byte;
    logic [CRC_W-1:0]  crc_step;
    logic [CRC_W-1:0]  crc_final;

    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;

    assign xored       = in_byte_reg ^ key_reg;
    assign cipher_byte = mode_reg ? in_byte_reg : xored;

    xcc_crc_byte u_crc_byte (
        .crc_in  (crc_reg),
        .byte_in (cipher_byte),
        .crc_out (crc_step)
    );

    assign crc_final = crc_step ^ CRC_XOROUT;
    assign crc_next  = in_last_reg ? CRC_INIT : crc_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CIPHER_KEY: key_reg  <= cfg_data;
                REG_CHECK_MODE: mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (in_adv)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_adv)
            begin
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg   <= s_tdata[BYTE_W-1:0];
            in_expect_reg <= s_tdata[BYTE_W+CRC_W-1:BYTE_W];
            in_last_reg   <= s_tlast;
        end
        if (in_adv)
        begin
            out_byte_reg  <= xored;
            out_last_reg  <= in_last_reg;
            out_crc_reg   <= in_last_reg ? crc_final : '0;
            out_match_reg <= in_last_reg && mode_reg && (crc_final == in_expect_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_crc_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_match_reg;

    `XCC_ASSERT_NEXT(a_crc_reload, in_adv && in_last_reg, crc_reg == CRC_INIT)
    `XCC_ASSERT_SAME(a_match_on_last, m_tvalid && m_tuser, m_tlast)
    `XCC_ASSERT_SAME(a_crc_zero_mid, m_tvalid && !m_tlast, m_tdata[TDATA_W-1:BYTE_W] == '0)
    `XCC_ASSERT_NEXT(a_input_held, in_valid_reg && !out_adv, in_valid_reg)

endmodule

`default_nettype wire
